/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RMS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define RMS_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("assertion failed");
`else
`define RMS_ASSERT(lbl, clk, rstn, prop)
`define RMS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/rms_pkg.sv */
// shared constants and types of the rmsprop update block
package rms_pkg;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W = 12;
  localparam int AVG_W = 48;
  localparam int PADDR_W = 5;

  localparam logic [23:0] LR_RESET = 24'd66;
  localparam logic [23:0] DF_RESET = 24'd0;
  localparam logic [31:0] EPS_RESET = 32'd429;
  localparam logic [15:0] RHO_RESET = 16'd58982;

  typedef enum logic [2:0] {
    REG_LEARNING_RATE = 3'd0,
    REG_DECAY_FACTOR  = 3'd1,
    REG_DECAY_ENABLE  = 3'd2,
    REG_EPSILON       = 3'd3,
    REG_RHO           = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic              neg;
    logic [31:0]       w;
    logic [IDX_W-1:0]  idx;
    logic [55:0]       prod;
  } side_t;
endpackage

/* rtl/rms_if.sv */
// stream interfaces for update transactions and results
interface rms_in_if;
  import rms_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_W-1:0]    element_index;
  logic signed [31:0]  gradient;
  logic signed [31:0]  weight_in;
  modport source (output valid, mode, element_index, gradient, weight_in, input ready);
  modport sink (input valid, mode, element_index, gradient, weight_in, output ready);
endinterface

interface rms_out_if;
  import rms_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [31:0]  weight_out;
  logic [IDX_W-1:0]    out_index;
  modport source (output valid, weight_out, out_index, input ready);
  modport sink (input valid, weight_out, out_index, output ready);
endinterface

/* rtl/rms_ram.sv */
// generic simple dual port ram with registered read
module rms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/rms_sqrt.sv */
// pipelined integer square root, one result bit per stage
module rms_sqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [62:0]    rad_i,
  input  rms_pkg::side_t side_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output rms_pkg::side_t side_o
);
  import rms_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
    side_t       side;
  } sq_stage_t;

  logic      vld_q [33];
  sq_stage_t st_q [33];
  logic [64:0] delta [32];
  logic        take [32];

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      delta[k] = (65'(st_q[k].root) << (32 - k)) | (65'(1) << (62 - 2 * k));
      take[k] = {1'b0, st_q[k].rem} >= delta[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 33; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < 32; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem <= 64'(rad_i);
      st_q[0].root <= 32'd0;
      st_q[0].side <= side_i;
      for (int k = 0; k < 32; k++) begin
        st_q[k+1].rem <= take[k] ? (st_q[k].rem - delta[k][63:0]) : st_q[k].rem;
        st_q[k+1].root <= take[k] ? (st_q[k].root | (32'd1 << (31 - k))) : st_q[k].root;
        st_q[k+1].side <= st_q[k].side;
      end
    end
  end

  assign valid_o = vld_q[32];
  assign root_o = st_q[32].root;
  assign side_o = st_q[32].side;
endmodule

/* rtl/rmsprop_parameter_update.sv */
// rmsprop update top level: squared average store, root and divide pipelines, rate unit
// an accepted update passes stages 1..4, the root and divide pipelines and the output register
// throughput: one update per cycle while the output is not stalled; an update whose index matches one
// of the three previous in-flight updates waits; a tick or rate write blocks input until the rate unit is idle
// reset: control registers take their reset values, then a clearing pass of the
// average store runs during which no transaction is accepted
`include "assert_macros.svh"
module rmsprop_parameter_update (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rms_in_if.sink                       in_i,
  rms_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rms_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import rms_pkg::*;

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_MUL  = 3'b010,
    RS_DIV  = 3'b100
  } rate_state_e;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] d;
    logic [33:0] lo;
    logic [33:0] q;
    logic        ovf;
    side_t       side;
  } dv_stage_t;

  // configuration
  logic [23:0] lr_q, df_q;
  logic        de_q;
  logic [31:0] eps_q;
  logic [15:0] rho_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LR_RESET;
      df_q <= DF_RESET;
      de_q <= 1'b0;
      eps_q <= EPS_RESET;
      rho_q <= RHO_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LEARNING_RATE: lr_q <= pwdata[23:0];
        REG_DECAY_FACTOR:  df_q <= pwdata[23:0];
        REG_DECAY_ENABLE:  de_q <= pwdata[0];
        REG_EPSILON:       eps_q <= pwdata;
        REG_RHO:           rho_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LEARNING_RATE: prdata = 32'(lr_q);
      REG_DECAY_FACTOR:  prdata = 32'(df_q);
      REG_DECAY_ENABLE:  prdata = 32'(de_q);
      REG_EPSILON:       prdata = eps_q;
      REG_RHO:           prdata = 32'(rho_q);
      default:           prdata = 32'd0;
    endcase
  end

  // handshake control
  logic en, clear_done, rate_busy, hazard, upd_acc, tick_acc, accept;
  logic out_v_q;

  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en && clear_done && !rate_busy && !(!in_i.mode && hazard);
  assign accept = in_i.valid && in_i.ready;
  assign upd_acc = accept && !in_i.mode;
  assign tick_acc = accept && in_i.mode;

  // decayed rate unit
  rate_state_e rs_q;
  logic [31:0] ic_q;
  logic [23:0] cur_rate_q;
  logic [56:0] den_q, rem_q;
  logic [47:0] num_q;
  logic [23:0] quo_q;
  logic [5:0]  cnt_q;
  logic [57:0] trial;
  logic        qbit;
  logic [55:0] dprod;
  logic        rate_trig;

  assign rate_busy = (rs_q != RS_IDLE);
  assign rate_trig = tick_acc ||
                     (cfg_wr && (cfg_idx == REG_LEARNING_RATE || cfg_idx == REG_DECAY_FACTOR));
  assign dprod = 56'(df_q) * 56'(ic_q);
  assign trial = {rem_q, num_q[47]};
  assign qbit = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= RS_IDLE;
      ic_q <= 32'd0;
      cur_rate_q <= LR_RESET;
      cnt_q <= 6'd0;
    end else begin
      if (tick_acc) begin
        ic_q <= ic_q + 32'd1;
      end
      case (rs_q)
        RS_IDLE: begin
          if (rate_trig) begin
            rs_q <= RS_MUL;
          end
        end
        RS_MUL: begin
          cnt_q <= 6'd47;
          if (!rate_trig) begin
            rs_q <= RS_DIV;
          end
        end
        RS_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (rate_trig) begin
            rs_q <= RS_MUL;
          end else if (cnt_q == 6'd0) begin
            cur_rate_q <= {quo_q[22:0], qbit};
            rs_q <= RS_IDLE;
          end
        end
        default: rs_q <= RS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rs_q == RS_MUL) begin
      den_q <= 57'(1 << 24) + {1'b0, dprod};
      num_q <= {lr_q, 24'd0};
      rem_q <= 57'd0;
      quo_q <= 24'd0;
    end else if (rs_q == RS_DIV) begin
      rem_q <= qbit ? 57'(trial - {1'b0, den_q}) : trial[56:0];
      num_q <= {num_q[46:0], 1'b0};
      quo_q <= {quo_q[22:0], qbit};
    end
  end

  // average store with clearing pass
  logic [ADDR_W:0]   clr_q;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [AVG_W-1:0]  ram_wdata, ram_rdata;

  assign clear_done = (clr_q == (ADDR_W + 1)'(STORE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (!clear_done) begin
      clr_q <= clr_q + (ADDR_W + 1)'(1);
    end
  end

  // stage 1..4 registers
  logic              s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic              s1_neg_q, s2_neg_q, s3_neg_q, s4_neg_q;
  logic              s1_st_q, s2_st_q, s3_st_q;
  logic [31:0]       s1_mag_q, s1_w_q, s2_w_q, s3_w_q, s4_w_q;
  logic [IDX_W-1:0]  s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic [23:0]       s1_rate_q;
  logic [63:0]       s2_sq_q, s3_a_q;
  logic [39:0]       s2_ahi_q, s2_alo_q;
  logic [55:0]       s2_prod_q, s3_prod_q, s4_prod_q;
  logic [48:0]       s3_skh_q, s3_skl_q;
  logic [AVG_W-1:0]  s4_avg_q;
  logic [AVG_W-1:0]  prev;
  logic [16:0]       kk;
  logic [80:0]       sum;
  logic [AVG_W-1:0]  avg_new;
  logic [31:0]       in_mag;
  logic              in_store;

  assign in_mag = in_i.gradient[31] ? (32'd0 - in_i.gradient) : in_i.gradient;
  assign in_store = 32'(in_i.element_index) < 32'(STORE_DEPTH);
  assign hazard = (s1_v_q && s1_idx_q == in_i.element_index) ||
                  (s2_v_q && s2_idx_q == in_i.element_index) ||
                  (s3_v_q && s3_idx_q == in_i.element_index);
  assign prev = s1_st_q ? ram_rdata : '0;
  assign kk = 17'h10000 - 17'(rho_q);
  assign sum = 81'(s3_a_q) + (81'(s3_skh_q) << 32) + 81'(s3_skl_q);
  assign avg_new = (sum[80:64] != 17'd0) ? {AVG_W{1'b1}} : sum[63:16];

  assign ram_re = upd_acc;
  assign ram_raddr = ADDR_W'(in_i.element_index);
  assign ram_we = !clear_done || (en && s3_v_q && s3_st_q);
  assign ram_waddr = !clear_done ? clr_q[ADDR_W-1:0] : ADDR_W'(s3_idx_q);
  assign ram_wdata = !clear_done ? '0 : avg_new;

  rms_ram #(
    .WIDTH (AVG_W),
    .DEPTH (STORE_DEPTH)
  ) u_avg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= upd_acc;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_neg_q <= in_i.gradient[31];
      s1_mag_q <= in_mag;
      s1_w_q <= in_i.weight_in;
      s1_idx_q <= in_i.element_index;
      s1_st_q <= in_store;
      s1_rate_q <= de_q ? cur_rate_q : lr_q;

      s2_neg_q <= s1_neg_q;
      s2_w_q <= s1_w_q;
      s2_idx_q <= s1_idx_q;
      s2_st_q <= s1_st_q;
      s2_sq_q <= 64'(s1_mag_q) * 64'(s1_mag_q);
      s2_ahi_q <= 40'(rho_q) * 40'(prev[47:24]);
      s2_alo_q <= 40'(rho_q) * 40'(prev[23:0]);
      s2_prod_q <= 56'(s1_rate_q) * 56'(s1_mag_q);

      s3_neg_q <= s2_neg_q;
      s3_w_q <= s2_w_q;
      s3_idx_q <= s2_idx_q;
      s3_st_q <= s2_st_q;
      s3_prod_q <= s2_prod_q;
      s3_a_q <= (64'(s2_ahi_q) << 24) + 64'(s2_alo_q);
      s3_skh_q <= 49'(s2_sq_q[63:32]) * 49'(kk);
      s3_skl_q <= 49'(s2_sq_q[31:0]) * 49'(kk);

      s4_neg_q <= s3_neg_q;
      s4_w_q <= s3_w_q;
      s4_idx_q <= s3_idx_q;
      s4_prod_q <= s3_prod_q;
      s4_avg_q <= avg_new;
    end
  end

  // square root of (avg + epsilon) scaled by 2^14
  logic        sq_v;
  logic [31:0] sq_root;
  side_t       sq_side, s4_side;
  logic [48:0] rad_sum;

  assign rad_sum = 49'(s4_avg_q) + 49'(eps_q);
  assign s4_side = '{neg: s4_neg_q, w: s4_w_q, idx: s4_idx_q, prod: s4_prod_q};

  rms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .rad_i   ({rad_sum, 14'd0}),
    .side_i  (s4_side),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // restoring divide pipeline, one quotient bit per stage
  logic        dv_v_q [35];
  dv_stage_t   dv_q [35];
  logic [32:0] dtrial [34];
  logic        dtake [34];
  logic [31:0] d0;
  logic [62:0] num0;

  assign d0 = (sq_root == 32'd0) ? 32'd1 : sq_root;
  assign num0 = {sq_side.prod, 7'd0};

  always_comb begin
    for (int k = 0; k < 34; k++) begin
      dtrial[k] = {dv_q[k].rem, dv_q[k].lo[33]};
      dtake[k] = dtrial[k] >= {1'b0, dv_q[k].d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 35; k++) begin
        dv_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_v_q[0] <= sq_v;
      for (int k = 0; k < 34; k++) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].rem <= 32'(num0[62:34]);
      dv_q[0].d <= d0;
      dv_q[0].lo <= num0[33:0];
      dv_q[0].q <= 34'd0;
      dv_q[0].ovf <= 32'(num0[62:34]) >= d0;
      dv_q[0].side <= sq_side;
      for (int k = 0; k < 34; k++) begin
        dv_q[k+1].rem <= dtake[k] ? 32'(dtrial[k] - {1'b0, dv_q[k].d}) : dtrial[k][31:0];
        dv_q[k+1].d <= dv_q[k].d;
        dv_q[k+1].lo <= {dv_q[k].lo[32:0], 1'b0};
        dv_q[k+1].q <= {dv_q[k].q[32:0], dtake[k]};
        dv_q[k+1].ovf <= dv_q[k].ovf;
        dv_q[k+1].side <= dv_q[k].side;
      end
    end
  end

  // step apply and output register
  localparam logic [33:0] QMAX = 34'h2_0000_0000;
  logic [33:0]        qv;
  logic signed [35:0] wext, res;
  logic [31:0]        res_sat;
  logic [31:0]        out_w_q;
  logic [IDX_W-1:0]   out_idx_q;

  assign qv = (dv_q[34].ovf || dv_q[34].q > QMAX) ? QMAX : dv_q[34].q;
  assign wext = 36'(signed'(dv_q[34].side.w));
  assign res = dv_q[34].side.neg ? (wext + signed'(36'(qv))) : (wext - signed'(36'(qv)));
  assign res_sat = (res > 36'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF :
                   (res < -36'sh0_8000_0000) ? 32'h8000_0000 : res[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[34];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_w_q <= res_sat;
      out_idx_q <= dv_q[34].side.idx;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.weight_out = out_w_q;
  assign out_o.out_index = out_idx_q;

  `RMS_ASSERT(a_no_accept_in_clear, clk_i, rst_ni, !clear_done |-> !in_i.ready)
  `RMS_ASSERT(a_no_accept_in_rate, clk_i, rst_ni, rate_busy |-> !in_i.ready)
  `RMS_NEVER(a_ram_rw_collide, clk_i, rst_ni, ram_we && ram_re && (ram_waddr == ram_raddr))
endmodule
